[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is asserted.
`define ETC1_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ETC1_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/etc1_pkg.sv]
// ----------------------------------------------------------------------------
// etc1_pkg
// Shared types, constants and color helpers of the ETC1 block decoder.
// ----------------------------------------------------------------------------
package etc1_pkg;

    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 13'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1
    } cfg_reg_t;

    localparam int COORD_W = 12;
    // block position as seen on the masked 12-bit coordinates
    localparam int BPOS_W  = COORD_W - 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    typedef struct packed {
        rgb_t              base0;
        rgb_t              base1;
        logic [2:0]        tbl0;
        logic [2:0]        tbl1;
        logic              flip;
        logic [31:0]       pix_bits;
        logic [BPOS_W-1:0] bx;
        logic [BPOS_W-1:0] by;
        logic [1:0]        last_row;
        logic [1:0]        last_col;
        logic              final_blk;
    } block_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [7:0] MOD_TABLE [8][2] = '{
        '{8'd2,  8'd8},  '{8'd5,  8'd17}, '{8'd9,  8'd29},  '{8'd13, 8'd42},
        '{8'd18, 8'd60}, '{8'd24, 8'd80}, '{8'd33, 8'd106}, '{8'd47, 8'd183}
    };

    function automatic logic [7:0] expand4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    // second differential color: 5-bit base plus signed 3-bit delta, wrapping
    function automatic logic [7:0] diff5(input logic [4:0] base, input logic [2:0] d);
        logic [4:0] sum;
        sum = base + {d[2], d[2], d};
        return expand5(sum);
    endfunction

    function automatic logic [7:0] clamp_mod(input logic [7:0] base, input logic [7:0] mag,
                                             input logic neg);
        logic signed [9:0] s;
        s = neg ? ($signed({2'b00, base}) - $signed({2'b00, mag}))
                : ($signed({2'b00, base}) + $signed({2'b00, mag}));
        if (s < 0)
            return 8'd0;
        else if (s > 10'sd255)
            return 8'd255;
        else
            return s[7:0];
    endfunction

endpackage

[rtl/etc1_front.sv]
// ----------------------------------------------------------------------------
// etc1_front
// Accepts blocks, tracks block position, decodes base colors and edge limits.
// ----------------------------------------------------------------------------
module etc1_front #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                block_valid,
    input  logic [63:0]                         block_word,
    output logic                                block_stall,
    input  logic                                cfg_valid,
    input  logic [etc1_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [etc1_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                cfg_ready,
    input  etc1_pkg::queue_status_t             q_status,
    output logic                                q_push,
    output etc1_pkg::block_entry_t              q_entry
);

    localparam int DIM_W   = $clog2(MAX_DIMENSION + 1);
    localparam int BLK_RAW = $clog2((MAX_DIMENSION + 3) / 4);
    localparam int BLK_W   = (BLK_RAW < 1) ? 1 : BLK_RAW;
    localparam int CMP_W   = (DIM_W > etc1_pkg::CFG_DATA_W) ? DIM_W : etc1_pkg::CFG_DATA_W;
    localparam int BX_W    = DIM_W + 1;
    localparam int PW      = DIM_W + 2;

    logic [etc1_pkg::CFG_DATA_W-1:0] width_reg, height_reg;
    logic [BLK_W-1:0]                col_reg, col_next;
    logic [BLK_W-1:0]                line_reg, line_next;

    logic [DIM_W-1:0] eff_w, eff_h;
    logic [BX_W-1:0]  blocks_x, blocks_y;
    logic [PW-1:0]    x0, y0, rem_x, rem_y;
    logic             has_pixels, accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= etc1_pkg::DIM_RESET;
            height_reg <= etc1_pkg::DIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == etc1_pkg::REG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            else if (cfg_index == etc1_pkg::REG_IMAGE_HEIGHT)
                height_reg <= cfg_data;
        end
    end

    // zero reads as one, oversize as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [etc1_pkg::CFG_DATA_W-1:0] v);
        if (v == '0)
            return DIM_W'(1);
        else if (CMP_W'(v) > CMP_W'(MAX_DIMENSION))
            return DIM_W'(MAX_DIMENSION);
        else
            return DIM_W'(v);
    endfunction

    always_comb
    begin
        eff_w    = eff_dim(width_reg);
        eff_h    = eff_dim(height_reg);
        blocks_x = (BX_W'(eff_w) + BX_W'(3)) >> 2;
        blocks_y = (BX_W'(eff_h) + BX_W'(3)) >> 2;
        x0       = PW'({col_reg, 2'b00});
        y0       = PW'({line_reg, 2'b00});
        rem_x    = PW'(eff_w) - x0;
        rem_y    = PW'(eff_h) - y0;
        has_pixels = (x0 < PW'(eff_w)) && (y0 < PW'(eff_h));
    end

    assign block_stall = q_status.full;
    assign accept      = block_valid && !q_status.full;
    assign q_push      = accept && has_pixels;

    // wrap the block position after the last block of a row and of the image
    always_comb
    begin
        col_next  = col_reg;
        line_next = line_reg;
        if (accept)
        begin
            if (BX_W'(col_reg) + BX_W'(1) >= blocks_x)
            begin
                col_next = '0;
                if (BX_W'(line_reg) + BX_W'(1) >= blocks_y)
                    line_next = '0;
                else
                    line_next = line_reg + BLK_W'(1);
            end
            else
            begin
                col_next = col_reg + BLK_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

    always_comb
    begin
        q_entry = '0;
        if (block_word[33])
        begin
            q_entry.base0.r = etc1_pkg::expand5(block_word[63:59]);
            q_entry.base1.r = etc1_pkg::diff5(block_word[63:59], block_word[58:56]);
            q_entry.base0.g = etc1_pkg::expand5(block_word[55:51]);
            q_entry.base1.g = etc1_pkg::diff5(block_word[55:51], block_word[50:48]);
            q_entry.base0.b = etc1_pkg::expand5(block_word[47:43]);
            q_entry.base1.b = etc1_pkg::diff5(block_word[47:43], block_word[42:40]);
        end
        else
        begin
            q_entry.base0.r = etc1_pkg::expand4(block_word[63:60]);
            q_entry.base1.r = etc1_pkg::expand4(block_word[59:56]);
            q_entry.base0.g = etc1_pkg::expand4(block_word[55:52]);
            q_entry.base1.g = etc1_pkg::expand4(block_word[51:48]);
            q_entry.base0.b = etc1_pkg::expand4(block_word[47:44]);
            q_entry.base1.b = etc1_pkg::expand4(block_word[43:40]);
        end
        q_entry.tbl0      = block_word[39:37];
        q_entry.tbl1      = block_word[36:34];
        q_entry.flip      = block_word[32];
        q_entry.pix_bits  = block_word[31:0];
        q_entry.bx        = etc1_pkg::BPOS_W'(col_reg);
        q_entry.by        = etc1_pkg::BPOS_W'(line_reg);
        q_entry.last_col  = (rem_x >= PW'(4)) ? 2'd3 : (rem_x[1:0] - 2'd1);
        q_entry.last_row  = (rem_y >= PW'(4)) ? 2'd3 : (rem_y[1:0] - 2'd1);
        q_entry.final_blk = (BX_W'(col_reg) == blocks_x - BX_W'(1)) &&
                            (BX_W'(line_reg) == blocks_y - BX_W'(1));
    end

endmodule

[rtl/etc1_queue.sv]
// ----------------------------------------------------------------------------
// etc1_queue
// Two-entry block queue between the front and the pixel sequencer.
// ----------------------------------------------------------------------------
module etc1_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  etc1_pkg::block_entry_t        entry,
    input  logic                          pop,
    output etc1_pkg::block_entry_t        head,
    output etc1_pkg::queue_status_t       status
);

    etc1_pkg::block_entry_t mem [etc1_pkg::QUEUE_DEPTH];

    logic [etc1_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [etc1_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [etc1_pkg::QCNT_W-1:0] count_reg, count_next;

    function automatic logic [etc1_pkg::QPTR_W-1:0] ptr_inc(
        input logic [etc1_pkg::QPTR_W-1:0] p);
        if (p == etc1_pkg::QPTR_W'(etc1_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + etc1_pkg::QPTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= entry;
    end

    assign head         = mem[rd_ptr_reg];
    assign status.full  = (count_reg == etc1_pkg::QCNT_W'(etc1_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + etc1_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - etc1_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/etc1_back.sv]
// ----------------------------------------------------------------------------
// etc1_back
// Walks the pixels of the head block, applies modifiers, registers output.
// ----------------------------------------------------------------------------
module etc1_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  etc1_pkg::queue_status_t            q_status,
    input  etc1_pkg::block_entry_t             q_head,
    output logic                               q_pop,
    output logic                               pixel_valid,
    input  logic                               pixel_stall,
    output logic [etc1_pkg::COORD_W-1:0]       pixel_x,
    output logic [etc1_pkg::COORD_W-1:0]       pixel_y,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic                               block_end,
    output logic                               image_end
);

    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic       valid_reg, valid_next;

    logic [etc1_pkg::COORD_W-1:0] x_reg, y_reg;
    logic [7:0]                   r_reg, g_reg, b_reg;
    logic                         bend_reg, iend_reg;

    logic            out_free, advance, last_pix, sub, lsb, msb;
    logic [3:0]      idx;
    logic [7:0]      mag;
    etc1_pkg::rgb_t  base;
    logic [2:0]      tbl;

    assign out_free = !valid_reg || !pixel_stall;
    assign advance  = out_free && !q_status.empty;
    assign last_pix = (row_reg == q_head.last_row) && (col_reg == q_head.last_col);
    assign q_pop    = advance && last_pix;

    always_comb
    begin
        sub  = q_head.flip ? row_reg[1] : col_reg[1];
        idx  = {col_reg, row_reg};
        lsb  = q_head.pix_bits[{1'b0, idx}];
        msb  = q_head.pix_bits[{1'b1, idx}];
        base = sub ? q_head.base1 : q_head.base0;
        tbl  = sub ? q_head.tbl1 : q_head.tbl0;
        mag  = etc1_pkg::MOD_TABLE[tbl][lsb];
    end

    // row-major walk bounded by the block's visible extent
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        valid_next = valid_reg;
        if (out_free)
            valid_next = !q_status.empty;
        if (advance)
        begin
            if (col_reg == q_head.last_col)
            begin
                col_next = 2'd0;
                row_next = last_pix ? 2'd0 : row_reg + 2'd1;
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= 2'd0;
            col_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg    <= {q_head.bx, col_reg};
            y_reg    <= {q_head.by, row_reg};
            r_reg    <= etc1_pkg::clamp_mod(base.r, mag, msb);
            g_reg    <= etc1_pkg::clamp_mod(base.g, mag, msb);
            b_reg    <= etc1_pkg::clamp_mod(base.b, mag, msb);
            bend_reg <= last_pix;
            iend_reg <= last_pix && q_head.final_blk;
        end
    end

    assign pixel_valid = valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign red         = r_reg;
    assign green       = g_reg;
    assign blue        = b_reg;
    assign block_end   = bend_reg;
    assign image_end   = iend_reg;

endmodule

[rtl/etc1_block_decoder.sv]
// ----------------------------------------------------------------------------
// etc1_block_decoder
// ETC1 block decoder: 64-bit blocks in, clamped RGB pixels with coordinates out.
// ----------------------------------------------------------------------------
// Blocks arrive in row-major block order and each yields its visible pixels,
// row by row, one pixel per cycle from the registered output while pixel_stall
// is low; a block that lies wholly outside the image is taken and yields
// nothing. The pace is set by the pixel sequencer's single output port; a
// two-entry block queue lets new blocks be taken while pixels of earlier ones
// drain. Width and height registers (index 0 and 1) may be written only while
// the block is idle.
module etc1_block_decoder #(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               block_valid,
    output logic                               block_stall,
    input  logic [63:0]                        block_word,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [etc1_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [etc1_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                               pixel_valid,
    input  logic                               pixel_stall,
    output logic [etc1_pkg::COORD_W-1:0]       pixel_x,
    output logic [etc1_pkg::COORD_W-1:0]       pixel_y,
    output logic [7:0]                         red,
    output logic [7:0]                         green,
    output logic [7:0]                         blue,
    output logic                               block_end,
    output logic                               image_end
);

    etc1_pkg::queue_status_t q_status;
    etc1_pkg::block_entry_t  q_entry, q_head;
    logic                    q_push, q_pop;

    etc1_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_valid (block_valid),
        .block_word  (block_word),
        .block_stall (block_stall),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg_ready   (cfg_ready),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    etc1_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .entry  (q_entry),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_status)
    );

    etc1_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .block_end   (block_end),
        .image_end   (image_end)
    );

endmodule

[rtl/etc1_checker.sv]
// ----------------------------------------------------------------------------
// etc1_checker
// Port-level checks of the ETC1 block decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etc1_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    input  logic                               pixel_stall,
    input  logic [etc1_pkg::COORD_W-1:0]       pixel_x,
    input  logic [etc1_pkg::COORD_W-1:0]       pixel_y,
    input  logic [7:0]                         red,
    input  logic [7:0]                         green,
    input  logic [7:0]                         blue,
    input  logic                               block_end,
    input  logic                               image_end
);

    logic                                 held, xfer;
    logic [2*etc1_pkg::COORD_W+24:0]      pix_word;
    logic [2*etc1_pkg::COORD_W-5:0]       blk_pos;

    assign held     = pixel_valid && pixel_stall;
    assign xfer     = pixel_valid && !pixel_stall;
    assign pix_word = {pixel_x, pixel_y, red, green, blue, block_end};
    assign blk_pos  = {pixel_x[etc1_pkg::COORD_W-1:2], pixel_y[etc1_pkg::COORD_W-1:2]};

    // output register is cleared by the reset edge itself
    `ETC1_ASSERT_ALWAYS(a_no_pixel_in_reset, !rst_n |=> !pixel_valid, "pixel valid during reset")

    `ETC1_ASSERT(a_stall_hold, held |=> pixel_valid && $stable(pix_word), "stalled pixel changed")

    `ETC1_ASSERT(a_image_end_on_block_end, pixel_valid && image_end |-> block_end, "image end without block end")

    // a block in progress keeps streaming its pixels without a gap
    `ETC1_ASSERT(a_block_continues, xfer && !block_end |=> pixel_valid && $stable(blk_pos), "block interrupted")

endmodule

bind etc1_block_decoder etc1_checker u_checker (.*);

[sim/etc1_block_decoder_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etc1_block_decoder_test
// Self-checking bench for the ETC1 block decoder. Blocks are sent through the
// stall handshake and decoded independently in the bench. Each pixel that
// comes out is compared, in order, with the predicted pixel. The image size
// is changed between runs, including zero, oversized and mid-image changes.
// ----------------------------------------------------------------------------
module etc1_block_decoder_test;

    localparam int MAX_DIM      = 4096;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 40;
    // indexes with no register behind them; writes must be ignored
    localparam logic [etc1_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [etc1_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int INTENSITY [8][2] = '{
        '{2, 8}, '{5, 17}, '{9, 29}, '{13, 42},
        '{18, 60}, '{24, 80}, '{33, 106}, '{47, 183}
    };

    typedef struct packed {
        logic [etc1_pkg::COORD_W-1:0] x;
        logic [etc1_pkg::COORD_W-1:0] y;
        logic [7:0]                   r;
        logic [7:0]                   g;
        logic [7:0]                   b;
        logic                         blk_last;
        logic                         img_last;
    } pixel_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             block_valid = 1'b0;
    logic                             block_stall;
    logic [63:0]                      block_word = '0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [etc1_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [etc1_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             pixel_valid;
    logic                             pixel_stall = 1'b0;
    logic [etc1_pkg::COORD_W-1:0]     pixel_x;
    logic [etc1_pkg::COORD_W-1:0]     pixel_y;
    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic                             block_end;
    logic                             image_end;

    logic [63:0] texture_blocks [$];
    pixel_t      decoded_pixels [$];

    // decoder state as the bench sees it
    int img_w_reg = 4096;
    int img_h_reg = 4096;
    int blk_col   = 0;
    int blk_line  = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int errors         = 0;
    int blocks_sent    = 0;
    int empty_blocks   = 0;
    int pixels_checked = 0;
    int image_ends     = 0;
    int size_settings  = 1;
    int quiet_cycles   = 0;

    etc1_block_decoder #(
        .MAX_DIMENSION(MAX_DIM)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .block_valid (block_valid),
        .block_stall (block_stall),
        .block_word  (block_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .block_end   (block_end),
        .image_end   (image_end)
    );

    always #5 clk = ~clk;

    function automatic int dim_of(input int v);
        if (v == 0)
            return 1;
        if (v > MAX_DIM)
            return MAX_DIM;
        return v;
    endfunction

    function automatic logic [7:0] clamp8(input int v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic logic [63:0] pack_block(input logic [23:0] colors, input logic [2:0] t0,
                                               input logic [2:0] t1, input logic diff,
                                               input logic flip, input logic [31:0] pix);
        return {colors, t0, t1, diff, flip, pix};
    endfunction

    // Decode one block at the current position and queue its visible pixels.
    function automatic void decode_block(input logic [63:0] w);
        int         width, height, bx, by, n, row, col, x, y, idx, sub, mag, c;
        int         base [2][3];
        logic [4:0] b5, s5;
        logic [2:0] d3;
        logic [2:0] tsel [2];
        logic       last_blk;
        pixel_t     pix [16];

        width    = dim_of(img_w_reg);
        height   = dim_of(img_h_reg);
        bx       = (width + 3) / 4;
        by       = (height + 3) / 4;
        last_blk = (blk_col == bx - 1) && (blk_line == by - 1);
        tsel[0]  = w[39:37];
        tsel[1]  = w[36:34];

        for (c = 0; c < 3; c++)
        begin
            if (!w[33])
            begin
                base[0][c] = int'({w[60-8*c +: 4], w[60-8*c +: 4]});
                base[1][c] = int'({w[56-8*c +: 4], w[56-8*c +: 4]});
            end
            else
            begin
                b5 = w[59-8*c +: 5];
                d3 = w[56-8*c +: 3];
                s5 = b5 + {{2{d3[2]}}, d3};  // wraps mod 32
                base[0][c] = int'({b5, b5[4:2]});
                base[1][c] = int'({s5, s5[4:2]});
            end
        end

        n = 0;
        for (row = 0; row < 4; row++)
        begin
            y = blk_line * 4 + row;
            if (y >= height)
                break;
            for (col = 0; col < 4; col++)
            begin
                x = blk_col * 4 + col;
                if (x >= width)
                    break;
                idx = col * 4 + row;   // pixel index runs down columns
                sub = int'(w[32] ? (row >= 2) : (col >= 2));
                mag = INTENSITY[tsel[sub]][w[idx]];
                if (w[idx + 16])
                    mag = -mag;
                pix[n].x        = x[etc1_pkg::COORD_W-1:0];
                pix[n].y        = y[etc1_pkg::COORD_W-1:0];
                pix[n].r        = clamp8(base[sub][0] + mag);
                pix[n].g        = clamp8(base[sub][1] + mag);
                pix[n].b        = clamp8(base[sub][2] + mag);
                pix[n].blk_last = 1'b0;
                pix[n].img_last = 1'b0;
                n++;
            end
        end

        if (n > 0)
        begin
            pix[n-1].blk_last = 1'b1;
            pix[n-1].img_last = last_blk;
        end
        else
        begin
            empty_blocks++;
        end
        for (c = 0; c < n; c++)
            decoded_pixels.push_back(pix[c]);

        if (blk_col + 1 >= bx)
        begin
            blk_col  = 0;
            blk_line = (blk_line + 1 >= by) ? 0 : blk_line + 1;
        end
        else
        begin
            blk_col = blk_col + 1;
        end
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Block sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            block_valid <= 1'b0;
        end
        else
        begin
            if (block_valid && !block_stall)
            begin
                decode_block(block_word);
                blocks_sent++;
            end
            if (!block_valid || !block_stall)
            begin
                if (texture_blocks.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    block_word  <= texture_blocks.pop_front();
                    block_valid <= 1'b1;
                end
                else
                begin
                    block_valid <= 1'b0;
                end
            end
        end
    end

    // Pixel receiver and checker
    always @(posedge clk)
    begin : pixel_mon
        pixel_t want;
        if (!rst_n)
        begin
            pixel_stall <= 1'b0;
        end
        else
        begin
            if (pixel_valid && !pixel_stall)
            begin
                if (decoded_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t: pixel (%0d,%0d) arrived with none pending, expected none",
                             $time, pixel_x, pixel_y);
                end
                else
                begin
                    want = decoded_pixels.pop_front();
                    check_field("pixel_x", want.x, pixel_x);
                    check_field("pixel_y", want.y, pixel_y);
                    check_field("red", want.r, red);
                    check_field("green", want.g, green);
                    check_field("blue", want.b, blue);
                    check_field("block_end", want.blk_last, block_end);
                    check_field("image_end", want.img_last, image_end);
                    pixels_checked++;
                    if (want.img_last)
                        image_ends++;
                end
            end
            pixel_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: ends the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((block_valid && !block_stall) || (pixel_valid && !pixel_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d pixels still pending",
                         $time, IDLE_LIMIT, decoded_pixels.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Waits until every block is sent and every pixel is out, then lets the tail drain.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (texture_blocks.size() != 0 || block_valid || decoded_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [etc1_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [etc1_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == etc1_pkg::REG_IMAGE_WIDTH)
            img_w_reg = int'(val);
        else if (idx == etc1_pkg::REG_IMAGE_HEIGHT)
            img_h_reg = int'(val);
    endtask

    task automatic add_random(input int count);
        @(negedge clk);
        repeat (count) texture_blocks.push_back({$urandom, $urandom});
    endtask

    task automatic run_size(input int w, input int h, input int count);
        wait_idle();
        write_reg(etc1_pkg::REG_IMAGE_WIDTH, w[etc1_pkg::CFG_DATA_W-1:0]);
        write_reg(etc1_pkg::REG_IMAGE_HEIGHT, h[etc1_pkg::CFG_DATA_W-1:0]);
        size_settings++;
        add_random(count);
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial
    begin
        int t;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        set_idle(22, 71);

        // directed blocks at the reset size
        texture_blocks.push_back(pack_block(24'h000000, 3'd0, 3'd0, 1'b0, 1'b0, 32'h0000_0000));
        texture_blocks.push_back(pack_block(24'hFFFFFF, 3'd7, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF));
        texture_blocks.push_back(pack_block(24'hFFFFFF, 3'd7, 3'd7, 1'b0, 1'b0, 32'h0000_FFFF));
        texture_blocks.push_back(pack_block(24'h000000, 3'd7, 3'd7, 1'b0, 1'b1, 32'hFFFF_0000));
        // differential sums wrapping up (31+3) and down (0-4)
        texture_blocks.push_back(pack_block(24'hFB0480, 3'd1, 3'd2, 1'b1, 1'b0, 32'h1234_5678));
        texture_blocks.push_back(pack_block(24'h04FB87, 3'd3, 3'd4, 1'b1, 1'b1, 32'h9ABC_DEF0));
        for (t = 0; t < 8; t++)
            texture_blocks.push_back(pack_block(24'($urandom), t[2:0], 3'(7 - t), t[0], t[1],
                                                $urandom));

        run_size(1, 1, 8);
        wait_idle();
        write_reg(REG_SPARE_LO, 13'h1FFF);
        run_size(0, 0, 4);
        wait_idle();
        write_reg(REG_SPARE_HI, 13'h0003);
        run_size(4096, 1, 6);

        set_idle(71, 22);
        run_size(8191, 5, 6);
        // counters left mid-image: the first block falls outside the new size
        run_size(5, 7, 6);
        wait_idle();
        add_random(6);
        run_size(13, 6, 15);

        set_idle(0, 0);
        run_size(3, 3, 8);
        run_size(1, 4096, 6);
        run_size(8, 8, 20);
        run_size(17, 9, 15);

        wait_idle();
        $display("Sent %0d blocks (%0d fully clipped) over %0d image sizes",
                 blocks_sent, empty_blocks, size_settings);
        $display("Checked %0d pixels including %0d image ends, %0d errors",
                 pixels_checked, image_ends, errors);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
